@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL top level of the watchdog.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define EIW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst
`define EIW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/eiw_pkg.sv @@
// Types and constants shared by the execution integrity watchdog modules.
`default_nettype none

package eiw_pkg;

  // FNV-1a 32 constants
  localparam logic [31:0] FnvPrime = 32'h0100_0193;
  localparam logic [31:0] FnvBasis = 32'h811c_9dc5;

  // Event kinds
  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_EXEC  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  // Check results
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_INIT  = 2'd1;
  localparam logic [1:0] STAT_TOO_MANY = 2'd2;
  localparam logic [1:0] STAT_BAD_GAP  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_EXEC_LIMIT = 1'b0;
  localparam logic CFG_MAX_GAP    = 1'b1;

  // Register reset values
  localparam logic [7:0]  ExecLimitReset = 8'd64;
  localparam logic [31:0] MaxGapReset    = 32'd120000;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HFOLD,
    ST_OFOLD,
    ST_WB
  } eiw_state_t;

  // Control of the shared hash step unit
  typedef struct packed {
    logic        load;
    logic        step;
    logic [31:0] seed;
    logic [7:0]  data;
  } eiw_fnv_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/eiw_fnv_step.sv @@
// Shared FNV-1a step unit: one byte folded into the accumulator per cycle while step is high.
`default_nettype none

module eiw_fnv_step (
  input  logic                 clk,
  input  eiw_pkg::eiw_fnv_ctl_t ctl,
  output logic [31:0]          acc,
  output logic [31:0]          acc_next
);
  import eiw_pkg::*;

  // xor the byte in, then one 32-bit multiply by the prime
  assign acc_next = (acc ^ {24'd0, ctl.data}) * FnvPrime;

  // accumulator: seeded on load, advanced on step
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= ctl.seed;
    end else if (ctl.step) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/exec_integrity_watchdog.sv @@
// Top level of the execution integrity watchdog: sequencer, state and result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall  | mode[1:0], time_ms[47:0]
//  out     | output    | out_valid / out_stall| status[1:0], integrity_word[31:0]
//  cfg     | input     | cfg_we               | cfg_index[0], cfg_data[31:0]
//
//  Init and exec go from accept through 4 hash-update byte steps, 4 result byte
//  steps and writeback; check and the unused mode skip the hash-update steps.
//  The single multiplier in eiw_fnv_step does one byte per cycle while stepping.
//  in_stall is high while an item is in flight; a result waiting in the output
//  register does not block the next item, but writeback waits for that register.
//  rst is synchronous, active high; it clears all but the per-item and output data.
`default_nettype none

module exec_integrity_watchdog (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [47:0] time_ms,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] integrity_word,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import eiw_pkg::*;

  `include "assert_macros.svh"

  eiw_state_t   state, state_next;
  eiw_fnv_ctl_t fnv_ctl;
  logic [31:0]  acc, acc_next;

  logic [7:0]  exec_limit;
  logic [31:0] max_gap_ms;
  logic        initialised;
  logic [31:0] exec_count;
  logic [47:0] last_time;
  logic [31:0] integrity_hash;

  logic [1:0]  idx;
  logic [31:0] fold_word;
  logic [1:0]  res_status;
  logic [31:0] res_word;

  logic        accept;
  logic        out_load;
  logic [47:0] gap;
  logic        gap_bad;
  logic [1:0]  check_status;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == ST_WB) && (!out_valid || !out_stall);

  // check outcome from current state
  assign gap     = time_ms - last_time;
  assign gap_bad = (time_ms < last_time) || (gap > {16'd0, max_gap_ms});
  always_comb begin
    if (!initialised) begin
      check_status = STAT_NO_INIT;
    end else if (exec_count > {24'd0, exec_limit}) begin
      check_status = STAT_TOO_MANY;
    end else if (gap_bad) begin
      check_status = STAT_BAD_GAP;
    end else begin
      check_status = STAT_OK;
    end
  end

  // shared hash unit
  eiw_fnv_step u_fnv (
    .clk      (clk),
    .ctl      (fnv_ctl),
    .acc      (acc),
    .acc_next (acc_next)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and hash unit control
  always_comb begin
    state_next   = state;
    fnv_ctl.load = 1'b0;
    fnv_ctl.step = 1'b0;
    fnv_ctl.seed = integrity_hash;
    fnv_ctl.data = fold_word[{idx, 3'b000} +: 8];
    case (state)
      ST_IDLE: begin
        if (accept) begin
          fnv_ctl.load = 1'b1;
          case (mode)
            MODE_INIT: begin
              fnv_ctl.seed = FnvBasis;
              state_next   = ST_HFOLD;
            end
            MODE_EXEC: begin
              state_next = ST_HFOLD;
            end
            default: begin
              state_next = ST_OFOLD;
            end
          endcase
        end
      end
      ST_HFOLD: begin
        fnv_ctl.step = 1'b1;
        if (idx == 2'd3) begin
          state_next = ST_OFOLD;
        end
      end
      ST_OFOLD: begin
        fnv_ctl.step = 1'b1;
        if (idx == 2'd3) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exec_limit <= ExecLimitReset;
      max_gap_ms <= MaxGapReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXEC_LIMIT: exec_limit <= cfg_data[7:0];
        CFG_MAX_GAP:    max_gap_ms <= cfg_data;
        default:        exec_limit <= exec_limit;
      endcase
    end
  end

  // watchdog state and per-item working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initialised    <= 1'b0;
      exec_count     <= 32'd0;
      last_time      <= 48'd0;
      integrity_hash <= 32'd0;
      idx            <= 2'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          idx <= 2'd0;
          if (accept) begin
            res_status <= STAT_OK;
            fold_word  <= exec_count;
            case (mode)
              MODE_INIT: begin
                initialised <= 1'b1;
                exec_count  <= 32'd0;
                last_time   <= time_ms;
                fold_word   <= 32'd1;
              end
              MODE_EXEC: begin
                exec_count <= exec_count + 32'd1;
                last_time  <= time_ms;
                fold_word  <= exec_count + 32'd1;
              end
              MODE_CHECK: begin
                res_status <= check_status;
                if (initialised && (exec_count <= {24'd0, exec_limit})) begin
                  last_time <= time_ms;
                end
              end
              default: begin
                res_status <= STAT_OK;
              end
            endcase
          end
        end
        ST_HFOLD: begin
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            // hash update done; fold the count for the result next
            integrity_hash <= acc_next;
            fold_word      <= exec_count;
          end
        end
        ST_OFOLD: begin
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            res_word <= acc_next ^ last_time[31:0];
          end
        end
        default: begin
          idx <= 2'd0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= res_status;
      integrity_word <= res_word;
    end
  end

  // checks
  `EIW_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
  `EIW_ASSERT_NEXT(a_fold_advances, (state == ST_HFOLD) && (idx != 2'd3),
    (state == ST_HFOLD) && (idx == $past(idx) + 2'd1))
  `EIW_ASSERT_NEXT(a_exec_counts_one, accept && (mode == MODE_EXEC),
    exec_count == $past(exec_count) + 32'd1)
  `EIW_ASSERT_NEXT(a_uninit_check_keeps_time,
    accept && (mode == MODE_CHECK) && !initialised, $stable(last_time))
  `EIW_ASSERT_NOW(a_wb_not_overwrite, out_valid && out_stall && (state == ST_WB),
    !out_load)

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the execution integrity watchdog.
`timescale 1ns / 1ps

module testbench;
  import eiw_pkg::*;

  // Unused event kind, the block must ignore it
  localparam logic [1:0]  ModeSpare   = 2'd3;
  // FNV-1a 32 constants for the local hash chain
  localparam logic [31:0] FoldPrime   = 32'h0100_0193;
  localparam logic [31:0] FoldBasis   = 32'h811c_9dc5;
  // Settle time before register writes and at the end
  localparam int          DrainCycles = 16;
  localparam int          PhaseItems  = 105;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word;
  } report_t;

  typedef struct packed {
    logic        is_write;
    logic        reg_sel;
    logic [31:0] reg_val;
    logic [1:0]  kind;
    logic [47:0] stamp;
    logic        pinned;
    logic [1:0]  pin_status;
  } plan_row_t;

  // Block inputs, all known from time zero
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [1:0]  mode      = MODE_INIT;
  logic [47:0] time_ms   = 48'd0;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_EXEC_LIMIT;
  logic [31:0] cfg_data  = 32'd0;

  // Block outputs
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic [31:0] integrity_word;

  // Local copy of the watchdog state and its registers
  logic        armed       = 1'b0;
  logic [31:0] run_count   = 32'd0;
  logic [47:0] stamp_kept  = 48'd0;
  logic [31:0] chain_hash  = 32'd0;
  logic [7:0]  limit_copy  = ExecLimitReset;
  logic [31:0] gap_copy    = MaxGapReset;

  report_t     awaited_reports[$];
  plan_row_t   directed_plan[$];
  bit          calm          = 1'b0;
  int          fault_count   = 0;
  int          reports_seen  = 0;
  int          settings_used = 1;
  int          status_seen[4];

  exec_integrity_watchdog u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .time_ms       (time_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .integrity_word(integrity_word),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("timeout waiting for the watchdog");
    $display("testbench NOT OK");
    $finish;
  end

  // FNV-1a over the four little-endian bytes of a word
  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] acc;
    acc = h;
    for (int k = 0; k < 4; k++) begin
      acc = (acc ^ {24'd0, w[8*k +: 8]}) * FoldPrime;
    end
    return acc;
  endfunction

  // Advance the local watchdog state by one event and form its report
  task automatic watchdog_step(input logic [1:0] kind, input logic [47:0] now,
                               output report_t rep);
    rep.status = STAT_OK;
    case (kind)
      MODE_INIT: begin
        armed      = 1'b1;
        run_count  = 32'd0;
        stamp_kept = now;
        chain_hash = fnv_fold(FoldBasis, 32'd1);
      end
      MODE_EXEC: begin
        run_count  = run_count + 32'd1;
        stamp_kept = now;
        chain_hash = fnv_fold(chain_hash, run_count);
      end
      MODE_CHECK: begin
        if (!armed) begin
          rep.status = STAT_NO_INIT;
        end else if (run_count > {24'd0, limit_copy}) begin
          rep.status = STAT_TOO_MANY;
        end else begin
          if (now < stamp_kept || (now - stamp_kept) > {16'd0, gap_copy}) begin
            rep.status = STAT_BAD_GAP;
          end
          stamp_kept = now;
        end
      end
      default: ;
    endcase
    rep.word = fnv_fold(chain_hash, run_count) ^ stamp_kept[31:0];
  endtask

  // Table builders for the directed part
  task automatic plan_event(input logic [1:0] kind, input logic [47:0] stamp,
                            input logic pinned, input logic [1:0] pin_status);
    plan_row_t row;
    row = '0;
    row.kind       = kind;
    row.stamp      = stamp;
    row.pinned     = pinned;
    row.pin_status = pin_status;
    directed_plan.push_back(row);
  endtask

  task automatic plan_write(input logic sel, input logic [31:0] val);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_sel  = sel;
    row.reg_val  = val;
    directed_plan.push_back(row);
  endtask

  // Offer one item at a falling edge, hold it until accepted
  task automatic send_event(input logic [1:0] kind, input logic [47:0] stamp,
                            input logic pinned, input logic [1:0] pin_status);
    report_t rep;
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= kind;
    time_ms  <= stamp;
    do @(posedge clk); while (in_stall);
    watchdog_step(kind, stamp, rep);
    if (pinned) rep.status = pin_status;
    awaited_reports.push_back(rep);
    @(negedge clk);
  endtask

  // Drop the input, then wait until every report is back and the block has gone quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (sel == CFG_EXEC_LIMIT) limit_copy = val[7:0];
    else gap_copy = val;
    @(negedge clk);
  endtask

  // Receiver stalls at random outside the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 30);
  end

  // Compare each accepted report with the oldest expectation
  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      status_seen[status]++;
      if (awaited_reports.size() == 0) begin
        fault_count++;
        $display("%0t: report with nothing expected: status %0d word %h",
                 $time, status, integrity_word);
      end else begin
        want = awaited_reports.pop_front();
        if (status !== want.status) begin
          fault_count++;
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
        end
        if (integrity_word !== want.word) begin
          fault_count++;
          $display("%0t: integrity word expected %h got %h",
                   $time, want.word, integrity_word);
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [1:0]  kind;
    logic [47:0] pace;
    logic [47:0] stamp;
    int unsigned roll;

    // Directed table: edges of the check order, time extremes, register extremes
    plan_event(MODE_CHECK, 48'd0,              1'b1, STAT_NO_INIT);  // right after reset
    plan_event(MODE_EXEC,  48'd5,              1'b0, STAT_OK);       // exec before init
    plan_event(MODE_CHECK, 48'hFFFF_FFFF_FFFF, 1'b1, STAT_NO_INIT);
    plan_event(ModeSpare,  48'hFFFF_FFFF_FFFF, 1'b1, STAT_OK);       // ignored kind
    plan_event(MODE_INIT,  48'd100,            1'b0, STAT_OK);
    plan_event(MODE_CHECK, 48'd100,            1'b1, STAT_OK);       // zero gap
    plan_event(MODE_CHECK, 48'd99,             1'b1, STAT_BAD_GAP);  // time went back
    plan_event(MODE_CHECK, 48'd120099,         1'b1, STAT_OK);       // gap exactly at limit
    plan_event(MODE_CHECK, 48'd240100,         1'b1, STAT_BAD_GAP);  // one past the limit
    plan_event(MODE_INIT,  48'hFFFF_FFFF_FFFF, 1'b0, STAT_OK);       // init repeated
    plan_event(MODE_CHECK, 48'd0,              1'b1, STAT_BAD_GAP);
    plan_event(MODE_EXEC,  48'd1,              1'b0, STAT_OK);
    plan_event(MODE_CHECK, 48'd1,              1'b1, STAT_OK);
    plan_write(CFG_EXEC_LIMIT, 32'd0);
    plan_write(CFG_MAX_GAP,    32'hFFFF_FFFF);
    plan_event(MODE_CHECK, 48'd2,              1'b1, STAT_TOO_MANY);
    plan_event(MODE_INIT,  48'd0,              1'b0, STAT_OK);
    plan_event(MODE_CHECK, 48'h0000_FFFF_FFFF, 1'b1, STAT_OK);
    plan_event(MODE_CHECK, 48'h0001_FFFF_FFFF, 1'b1, STAT_BAD_GAP);
    plan_write(CFG_EXEC_LIMIT, 32'd255);
    plan_write(CFG_MAX_GAP,    32'd0);
    plan_event(MODE_EXEC,  48'd7,              1'b0, STAT_OK);
    plan_event(MODE_CHECK, 48'd7,              1'b1, STAT_OK);
    plan_event(MODE_CHECK, 48'd8,              1'b1, STAT_BAD_GAP);

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write) begin
        wait_idle();
        write_reg(directed_plan[i].reg_sel, directed_plan[i].reg_val);
        settings_used++;
      end else begin
        send_event(directed_plan[i].kind, directed_plan[i].stamp,
                   directed_plan[i].pinned, directed_plan[i].pin_status);
      end
    end

    // Random phases, each under its own register setting
    pace = 48'd0;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(CFG_EXEC_LIMIT, 32'd255);
          write_reg(CFG_MAX_GAP, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_EXEC_LIMIT, 32'd0);
          write_reg(CFG_MAX_GAP, 32'd0);
        end
        2: begin
          write_reg(CFG_EXEC_LIMIT, $urandom_range(1, 16));
          write_reg(CFG_MAX_GAP, $urandom_range(1, 5000));
        end
        default: begin
          write_reg(CFG_EXEC_LIMIT, {24'd0, ExecLimitReset});
          write_reg(CFG_MAX_GAP, MaxGapReset);
        end
      endcase
      settings_used++;

      for (int i = 0; i < PhaseItems; i++) begin
        calm = (p == 1 && i < 80);
        // Event kind: mostly exec and check runs, occasional init and spare
        roll = $urandom_range(0, 99);
        if (roll < 8)       kind = MODE_INIT;
        else if (roll < 50) kind = MODE_EXEC;
        else if (roll < 95) kind = MODE_CHECK;
        else                kind = ModeSpare;
        // Time: mostly forward within the gap, with edges, rewinds and noise
        roll = $urandom_range(0, 99);
        if (roll < 65)
          stamp = pace + {16'd0, 32'($urandom_range(0, gap_copy))};
        else if (roll < 75)
          stamp = pace + {16'd0, gap_copy};
        else if (roll < 85)
          stamp = pace + {16'd0, gap_copy} + 48'd1;
        else if (roll < 92)
          stamp = pace - 48'($urandom_range(1, 1000));
        else
          stamp = {16'($urandom), 32'($urandom)};
        pace = stamp;
        send_event(kind, stamp, 1'b0, STAT_OK);
      end
    end
    calm = 1'b0;

    wait_idle();
    $display("covered %0d reports under %0d register settings", reports_seen, settings_used);
    $display("statuses: ok %0d, not initialised %0d, over limit %0d, bad gap %0d",
             status_seen[STAT_OK], status_seen[STAT_NO_INIT],
             status_seen[STAT_TOO_MANY], status_seen[STAT_BAD_GAP]);
    if (fault_count == 0 && awaited_reports.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
